// File: sv/text_timecode_scanner_defines.svh
// assertion macros used by the scanner checker
`ifndef TEXT_TIMECODE_SCANNER_DEFINES_SVH
`define TEXT_TIMECODE_SCANNER_DEFINES_SVH

// same-cycle implication, off while reset is active
`define TTC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is active
`define TTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define TTC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ttc_pkg.sv
// types, constants and codes shared by the time code scanner modules
`timescale 1ns / 1ps

package ttc_pkg;

    // attempt slots and field widths
    localparam int ATTEMPT_SLOTS  = 4;
    localparam int FIELD_SAT_BITS = 34;
    localparam int FIELD_ACC_W    = FIELD_SAT_BITS + 4;  // room for one decimal step
    localparam int CLAMP_W        = 34;  // holds the clamped range limit plus one
    localparam int MILLIS_W       = 10;
    localparam int MILLI_DIGITS   = 3;
    localparam int FRAC_CNT_W     = 2;

    // queue between front and matcher, depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // result arithmetic widths
    localparam int HOUR_SEC_W  = 46;
    localparam int MIN_SEC_W   = 40;
    localparam int TOTAL_SEC_W = 46;
    localparam int SEC_NS_W    = 64;
    localparam int MS_NS_W     = 30;
    localparam int NS_W        = 63;

    // port widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    // characters
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_PERIOD = 8'h2E;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    // limits and scale factors
    localparam logic [FIELD_SAT_BITS-1:0] FIELD_MAX   = '1;
    localparam logic [FIELD_SAT_BITS-1:0] FIELD_LIMIT = FIELD_SAT_BITS'(64'd9223372036);
    localparam logic [CLAMP_W-1:0]        SECONDS_LIMIT = CLAMP_W'(64'd9223372036);
    localparam logic [CLAMP_W-1:0]        CLAMP_OVER    = CLAMP_W'(64'd9223372037);
    localparam logic [11:0]               SEC_PER_HOUR  = 12'd3600;
    localparam logic [5:0]                SEC_PER_MIN   = 6'd60;
    localparam logic [29:0]               NS_PER_SEC    = 30'd1000000000;
    localparam logic [19:0]               NS_PER_MS     = 20'd1000000;

    // character classes seen by the slots
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_DIGIT,
        CLS_SPACE,
        CLS_COLON,
        CLS_POINT
    } char_class_t;

    // classified text byte as queued for the matcher
    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        run_start;
        logic        last;
    } text_item_t;

    // attempt slot stages
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HOURS,
        ST_SP_H,
        ST_SP_C1,
        ST_MINUTES,
        ST_SP_M,
        ST_SP_C2,
        ST_SECONDS,
        ST_SP_S,
        ST_SP_DOT,
        ST_FRAC
    } stage_t;

    // matcher to slot control
    typedef struct packed {
        logic step;
        logic start;
        logic clear;
    } slot_ctrl_t;

    // slot to matcher status
    typedef struct packed {
        logic free_next;
        logic done;
    } slot_status_t;

    // raw fields of a completing attempt
    typedef struct packed {
        logic [FIELD_SAT_BITS-1:0] hours;
        logic [FIELD_SAT_BITS-1:0] minutes;
        logic [FIELD_SAT_BITS-1:0] seconds;
        logic [MILLIS_W-1:0]       millis;
    } slot_fields_t;

    // clamped fields of the recorded match
    typedef struct packed {
        logic [CLAMP_W-1:0]  hours;
        logic [CLAMP_W-1:0]  minutes;
        logic [CLAMP_W-1:0]  seconds;
        logic [MILLIS_W-1:0] millis;
    } time_fields_t;

    // end of text summary handed to the result pipeline
    typedef struct packed {
        logic         found;
        time_fields_t fields;
    } match_summary_t;

    typedef enum logic [1:0] {
        STATUS_FOUND = 2'd0,
        STATUS_NONE  = 2'd1,
        STATUS_RANGE = 2'd2
    } scan_status_t;

endpackage

// File: sv/text_timecode_scanner.sv
// top level of the streaming time code scanner
`timescale 1ns / 1ps
// throughput: one text byte per cycle while no last byte waits for the result side, set
//   by the attempt slots that all update in parallel on each byte; one result word per
//   text, after its last byte; the result passes the queue, the summary register and the
//   arithmetic stages ending in the output register, and any output stall holds it
// reset: aresetn is synchronous, active low; it empties the queue, idles every slot, drops
//   any recorded match and clears all pipeline valids, no clearing pass is needed

module text_timecode_scanner
    import ttc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // text byte stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] text_byte
    input  logic                  s_tlast,   // last_byte

    // result stream, one word per text
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [62:0] time_ns, [63] zero
    output logic [OUT_USER_W-1:0] m_tuser    // [1:0] scan_status
);

    // classified bytes between front and matcher
    logic           q_valid;
    logic           q_ready;
    text_item_t     q_item;

    // end of text summary between matcher and result pipeline
    logic           sum_valid;
    logic           sum_ready;
    match_summary_t sum;

    // front: takes a word whenever the queue has room, never waits on the result side
    ttc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // matcher: attempt slots advance on every queued byte until a match is recorded; only a last byte can stall here
    ttc_matcher u_matcher (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .sum_valid(sum_valid),
        .sum_ready(sum_ready),
        .sum      (sum)
    );

    // result pipeline: seconds total, range checks, nanoseconds, output register
    ttc_result u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sum_valid(sum_valid),
        .sum_ready(sum_ready),
        .sum      (sum),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: sv/ttc_front.sv
// input side: accepts text words, classifies each byte and queues it
`timescale 1ns / 1ps

module ttc_front
    import ttc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 q_valid,
    input  logic                 q_ready,
    output text_item_t           q_item
);

    text_item_t               queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                     prev_digit_reg, prev_digit_next;
    text_item_t               in_item;
    logic                     push, pop;

    // byte classification
    always_comb begin
        in_item.cls   = CLS_OTHER;
        in_item.digit = '0;
        if (s_tdata >= CHAR_ZERO && s_tdata <= CHAR_NINE) begin
            in_item.cls   = CLS_DIGIT;
            in_item.digit = s_tdata[3:0];  // ascii digits sit at 0x30
        end else if (s_tdata == CHAR_SPACE || (s_tdata >= CHAR_TAB && s_tdata <= CHAR_CR)) begin
            in_item.cls = CLS_SPACE;
        end else if (s_tdata == CHAR_COLON) begin
            in_item.cls = CLS_COLON;
        end else if (s_tdata == CHAR_PERIOD || s_tdata == CHAR_COMMA) begin
            in_item.cls = CLS_POINT;
        end
        in_item.run_start = (in_item.cls == CLS_DIGIT) && !prev_digit_reg;
        in_item.last      = s_tlast;
    end

    assign s_tready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next     = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next     = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next      = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
        prev_digit_next = prev_digit_reg;
        if (push) begin
            // digit runs never span two texts
            prev_digit_next = (in_item.cls == CLS_DIGIT) && !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            prev_digit_reg <= 1'b0;
        end else begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            prev_digit_reg <= prev_digit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: sv/ttc_slot.sv
// one match attempt slot: stage machine and saturating field accumulators
`timescale 1ns / 1ps

module ttc_slot
    import ttc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  slot_ctrl_t   ctrl,
    input  text_item_t   item,
    output slot_status_t status,
    output slot_fields_t fields
);

    stage_t                    stage_reg, stage_next, stage_adv;
    logic [FIELD_SAT_BITS-1:0] hours_reg, hours_next;
    logic [FIELD_SAT_BITS-1:0] minutes_reg, minutes_next;
    logic [FIELD_SAT_BITS-1:0] seconds_reg, seconds_next;
    logic [MILLIS_W-1:0]       millis_reg, millis_next;
    logic [FRAC_CNT_W-1:0]     frac_count_reg, frac_count_next;
    logic                      is_dig, is_sp, is_colon, is_point;
    logic                      frac_done;
    logic [FIELD_SAT_BITS-1:0] acc_src, acc_sat;
    logic [FIELD_ACC_W-1:0]    acc_wide;
    logic [MILLIS_W-1:0]       millis_acc;

    assign is_dig   = (item.cls == CLS_DIGIT);
    assign is_sp    = (item.cls == CLS_SPACE);
    assign is_colon = (item.cls == CLS_COLON);
    assign is_point = (item.cls == CLS_POINT);

    assign frac_done = (stage_reg == ST_FRAC) && is_dig
                       && (frac_count_reg == FRAC_CNT_W'(MILLI_DIGITS - 1));

    // stage advance on the current byte
    always_comb begin
        stage_adv = ST_IDLE;
        unique case (stage_reg)
            ST_IDLE: stage_adv = ST_IDLE;
            ST_HOURS: begin
                if (is_dig)        stage_adv = ST_HOURS;
                else if (is_sp)    stage_adv = ST_SP_H;
                else if (is_colon) stage_adv = ST_SP_C1;
            end
            ST_MINUTES: begin
                if (is_dig)        stage_adv = ST_MINUTES;
                else if (is_sp)    stage_adv = ST_SP_M;
                else if (is_colon) stage_adv = ST_SP_C2;
            end
            ST_SECONDS: begin
                if (is_dig)        stage_adv = ST_SECONDS;
                else if (is_sp)    stage_adv = ST_SP_S;
                else if (is_point) stage_adv = ST_SP_DOT;
            end
            ST_SP_H: begin
                if (is_sp)         stage_adv = ST_SP_H;
                else if (is_colon) stage_adv = ST_SP_C1;
            end
            ST_SP_M: begin
                if (is_sp)         stage_adv = ST_SP_M;
                else if (is_colon) stage_adv = ST_SP_C2;
            end
            ST_SP_S: begin
                if (is_sp)         stage_adv = ST_SP_S;
                else if (is_point) stage_adv = ST_SP_DOT;
            end
            ST_SP_C1: begin
                if (is_sp)       stage_adv = ST_SP_C1;
                else if (is_dig) stage_adv = ST_MINUTES;
            end
            ST_SP_C2: begin
                if (is_sp)       stage_adv = ST_SP_C2;
                else if (is_dig) stage_adv = ST_SECONDS;
            end
            ST_SP_DOT: begin
                if (is_sp)       stage_adv = ST_SP_DOT;
                else if (is_dig) stage_adv = ST_FRAC;
            end
            ST_FRAC: begin
                if (is_dig && !frac_done) stage_adv = ST_FRAC;
            end
            default: stage_adv = ST_IDLE;
        endcase
    end

    always_comb begin
        stage_next = stage_reg;
        if (ctrl.clear) begin
            stage_next = ST_IDLE;
        end else if (ctrl.start) begin
            stage_next = ST_HOURS;
        end else if (ctrl.step) begin
            stage_next = stage_adv;
        end
    end

    // shared accumulator for the field that is collecting digits
    always_comb begin
        unique case (stage_reg)
            ST_MINUTES: acc_src = minutes_reg;
            ST_SECONDS: acc_src = seconds_reg;
            default:    acc_src = hours_reg;
        endcase
        acc_wide = (FIELD_ACC_W'(acc_src) << 3) + (FIELD_ACC_W'(acc_src) << 1)
                 + FIELD_ACC_W'(item.digit);
        acc_sat  = (acc_wide[FIELD_ACC_W-1:FIELD_SAT_BITS] != '0)
                 ? FIELD_MAX : acc_wide[FIELD_SAT_BITS-1:0];
        millis_acc = (millis_reg << 3) + (millis_reg << 1) + MILLIS_W'(item.digit);
    end

    // field updates
    always_comb begin
        hours_next      = hours_reg;
        minutes_next    = minutes_reg;
        seconds_next    = seconds_reg;
        millis_next     = millis_reg;
        frac_count_next = frac_count_reg;
        if (ctrl.start) begin
            hours_next      = FIELD_SAT_BITS'(item.digit);
            minutes_next    = '0;
            seconds_next    = '0;
            millis_next     = '0;
            frac_count_next = '0;
        end else if (ctrl.step && is_dig) begin
            unique case (stage_reg)
                ST_HOURS:   hours_next   = acc_sat;
                ST_MINUTES: minutes_next = acc_sat;
                ST_SECONDS: seconds_next = acc_sat;
                ST_SP_C1:   minutes_next = FIELD_SAT_BITS'(item.digit);
                ST_SP_C2:   seconds_next = FIELD_SAT_BITS'(item.digit);
                ST_SP_DOT: begin
                    millis_next     = MILLIS_W'(item.digit);
                    frac_count_next = FRAC_CNT_W'(1);
                end
                ST_FRAC: begin
                    millis_next     = millis_acc;
                    frac_count_next = frac_count_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign status.free_next = (stage_adv == ST_IDLE);
    assign status.done      = frac_done;
    assign fields.hours     = hours_reg;
    assign fields.minutes   = minutes_reg;
    assign fields.seconds   = seconds_reg;
    assign fields.millis    = millis_acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ST_IDLE;
        end else begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge aclk) begin
        hours_reg      <= hours_next;
        minutes_reg    <= minutes_next;
        seconds_reg    <= seconds_next;
        millis_reg     <= millis_next;
        frac_count_reg <= frac_count_next;
    end

endmodule

// File: sv/ttc_matcher.sv
// back end: drives the attempt slots, records the leftmost match, emits end of text summary
`timescale 1ns / 1ps

module ttc_matcher
    import ttc_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  text_item_t     q_item,
    output logic           sum_valid,
    input  logic           sum_ready,
    output match_summary_t sum
);

    slot_ctrl_t    slot_ctrl   [ATTEMPT_SLOTS];
    slot_status_t  slot_status [ATTEMPT_SLOTS];
    slot_fields_t  slot_fields [ATTEMPT_SLOTS];

    logic          match_found_reg, match_found_next;
    time_fields_t  rec_reg, rec_next;
    logic          pop, step, clear, any_done, new_match, alloc_req, taken;
    logic [ATTEMPT_SLOTS-1:0] start_vec;
    slot_fields_t  pick;
    time_fields_t  pick_clamped;

    function automatic logic [CLAMP_W-1:0] clamp_field(input logic [FIELD_SAT_BITS-1:0] v);
        logic [CLAMP_W-1:0] r;
        r = (v > FIELD_LIMIT) ? CLAMP_OVER : v[CLAMP_W-1:0];
        return r;
    endfunction

    // a last byte waits until the result side can take its summary
    assign q_ready   = !q_item.last || sum_ready;
    assign pop       = q_valid && q_ready;
    assign step      = pop && !match_found_reg;
    assign clear     = pop && q_item.last;

    // lowest slot index wins among attempts completing together
    always_comb begin
        any_done = 1'b0;
        pick     = slot_fields[0];
        for (int k = ATTEMPT_SLOTS - 1; k >= 0; k--) begin
            if (slot_status[k].done) begin
                any_done = 1'b1;
                pick     = slot_fields[k];
            end
        end
    end

    assign new_match = step && any_done;
    assign alloc_req = step && !any_done && q_item.run_start;

    // new attempt goes to the first slot that is free after this byte
    always_comb begin
        taken = 1'b0;
        for (int k = 0; k < ATTEMPT_SLOTS; k++) begin
            start_vec[k] = alloc_req && slot_status[k].free_next && !taken;
            taken        = taken || start_vec[k];
        end
    end

    always_comb begin
        for (int k = 0; k < ATTEMPT_SLOTS; k++) begin
            slot_ctrl[k].step  = step;
            slot_ctrl[k].start = start_vec[k];
            slot_ctrl[k].clear = clear;
        end
    end

    generate
        for (genvar g = 0; g < ATTEMPT_SLOTS; g++) begin : g_slot
            ttc_slot u_slot (
                .aclk   (aclk),
                .aresetn(aresetn),
                .ctrl   (slot_ctrl[g]),
                .item   (q_item),
                .status (slot_status[g]),
                .fields (slot_fields[g])
            );
        end
    endgenerate

    always_comb begin
        pick_clamped.hours   = clamp_field(pick.hours);
        pick_clamped.minutes = clamp_field(pick.minutes);
        pick_clamped.seconds = clamp_field(pick.seconds);
        pick_clamped.millis  = pick.millis;

        match_found_next = clear ? 1'b0 : (match_found_reg || new_match);
        rec_next         = new_match ? pick_clamped : rec_reg;

        sum.found  = match_found_reg || new_match;
        sum.fields = match_found_reg ? rec_reg : pick_clamped;
    end

    assign sum_valid = q_valid && q_item.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_found_reg <= 1'b0;
        end else begin
            match_found_reg <= match_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

endmodule

// File: sv/ttc_result.sv
// result pipeline: seconds total, range checks, nanosecond conversion, output register
`timescale 1ns / 1ps

module ttc_result
    import ttc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  sum_valid,
    output logic                  sum_ready,
    input  match_summary_t        sum,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    logic                   en;

    logic                   s0_valid_reg, s0_valid_next;
    match_summary_t         s0_sum_reg;

    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_found_reg;
    logic [HOUR_SEC_W-1:0]  s1_hour_sec_reg, s1_hour_sec_next;
    logic [MIN_SEC_W-1:0]   s1_min_sec_reg, s1_min_sec_next;
    logic [CLAMP_W-1:0]     s1_sec_reg;
    logic [MILLIS_W-1:0]    s1_millis_reg;

    logic                   s2_valid_reg, s2_valid_next;
    logic                   s2_found_reg;
    logic [TOTAL_SEC_W-1:0] s2_total_reg, s2_total_next;
    logic [MILLIS_W-1:0]    s2_millis_reg;

    logic                   s3_valid_reg, s3_valid_next;
    logic                   s3_found_reg;
    logic                   s3_over_reg, s3_over_next;
    logic [SEC_NS_W-1:0]    s3_sec_ns_reg, s3_sec_ns_next;
    logic [MS_NS_W-1:0]     s3_ms_ns_reg, s3_ms_ns_next;

    logic                   out_valid_reg, out_valid_next;
    scan_status_t           status_reg, status_next;
    logic [NS_W-1:0]        ns_reg, ns_next;
    logic [SEC_NS_W-1:0]    ns_sum;

    // whole pipeline moves together unless the output word is held
    assign en        = !out_valid_reg || m_tready;
    assign sum_ready = en;

    always_comb begin
        s0_valid_next  = sum_valid;
        s1_valid_next  = s0_valid_reg;
        s2_valid_next  = s1_valid_reg;
        s3_valid_next  = s2_valid_reg;
        out_valid_next = s3_valid_reg;

        s1_hour_sec_next = HOUR_SEC_W'(s0_sum_reg.fields.hours) * HOUR_SEC_W'(SEC_PER_HOUR);
        s1_min_sec_next  = MIN_SEC_W'(s0_sum_reg.fields.minutes) * MIN_SEC_W'(SEC_PER_MIN);

        s2_total_next = TOTAL_SEC_W'(s1_hour_sec_reg) + TOTAL_SEC_W'(s1_min_sec_reg)
                      + TOTAL_SEC_W'(s1_sec_reg);

        // product only matters when the total is within the limit
        s3_over_next   = s2_total_reg > TOTAL_SEC_W'(SECONDS_LIMIT);
        s3_sec_ns_next = SEC_NS_W'(s2_total_reg[CLAMP_W-1:0]) * SEC_NS_W'(NS_PER_SEC);
        s3_ms_ns_next  = MS_NS_W'(s2_millis_reg) * MS_NS_W'(NS_PER_MS);

        ns_sum      = s3_sec_ns_reg + SEC_NS_W'(s3_ms_ns_reg);
        status_next = STATUS_FOUND;
        ns_next     = ns_sum[NS_W-1:0];
        if (!s3_found_reg) begin
            status_next = STATUS_NONE;
            ns_next     = '0;
        end else if (s3_over_reg || ns_sum[SEC_NS_W-1]) begin
            status_next = STATUS_RANGE;
            ns_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg  <= s0_valid_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_sum_reg      <= sum;

            s1_found_reg    <= s0_sum_reg.found;
            s1_hour_sec_reg <= s1_hour_sec_next;
            s1_min_sec_reg  <= s1_min_sec_next;
            s1_sec_reg      <= s0_sum_reg.fields.seconds;
            s1_millis_reg   <= s0_sum_reg.fields.millis;

            s2_found_reg    <= s1_found_reg;
            s2_total_reg    <= s2_total_next;
            s2_millis_reg   <= s1_millis_reg;

            s3_found_reg    <= s2_found_reg;
            s3_over_reg     <= s3_over_next;
            s3_sec_ns_reg   <= s3_sec_ns_next;
            s3_ms_ns_reg    <= s3_ms_ns_next;

            status_reg      <= status_next;
            ns_reg          <= ns_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(ns_reg);
    assign m_tuser  = status_reg;

endmodule

// File: sv/ttc_checker.sv
// port level checks on the scanner result stream, bound to the top level
`timescale 1ns / 1ps
`include "text_timecode_scanner_defines.svh"

module ttc_checker
    import ttc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // a held result word keeps its contents
    `TTC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // time is zero unless a time code was found in range
    `TTC_ASSERT_IMPL(a_zero_time, aclk, aresetn, m_tvalid && (m_tuser != STATUS_FOUND), m_tdata == '0, "nonzero time with a not-found or range status")

    // nanoseconds never reach the top data bit
    `TTC_ASSERT_IMPL(a_pad_bit, aclk, aresetn, m_tvalid, !m_tdata[OUT_DATA_W-1], "time exceeds 63 bits")

    // reset leaves no result pending
    `TTC_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid, "result valid right after reset")

endmodule

bind text_timecode_scanner ttc_checker u_ttc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

// File: bench/tb_text_timecode_scanner.sv
// self-checking testbench for the streaming time code scanner
`timescale 1ns / 1ps

module tb_text_timecode_scanner;
    import ttc_pkg::*;

    localparam logic [63:0] FIELD_TOP    = (64'd1 << FIELD_SAT_BITS) - 64'd1;
    localparam logic [63:0] SECONDS_CAP  = 64'd9223372036;
    localparam logic [63:0] NS_CAP       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          TEXT_BYTES   = 550;
    localparam int          DRAIN_CYCLES = 40;

    typedef struct packed {
        scan_status_t    status;
        logic [NS_W-1:0] ns;
    } scan_result_t;

    typedef logic [7:0] byte_seq_t [$];

    // directed texts; pinned rows carry the result typed in, the rest use the scan model
    typedef struct {
        bit              lead_nul;
        string           text;
        bit              pinned;
        scan_status_t    status;
        logic [NS_W-1:0] ns;
    } text_case_t;

    text_case_t directed_cases [17] = '{
        '{1'b0, "7",                    1'b1, STATUS_NONE,  '0},
        '{1'b1, "\377\001",             1'b1, STATUS_NONE,  '0},
        '{1'b0, "0:0:0.000",            1'b1, STATUS_FOUND, '0},
        '{1'b0, "1:2:3.456",            1'b1, STATUS_FOUND, 63'd3723456000000},
        '{1'b0, "2562047:47:16.854",    1'b1, STATUS_FOUND, 63'd9223372036854000000},
        '{1'b0, "2562047:47:16,855",    1'b1, STATUS_RANGE, '0},
        '{1'b0, "2562047:47:17.000",    1'b1, STATUS_RANGE, '0},
        '{1'b0, "99999999999:0:0.000",  1'b1, STATUS_RANGE, '0},
        '{1'b0, "0:0:99999999999,999",  1'b1, STATUS_RANGE, '0},
        '{1'b0, "1:2:3.45",             1'b1, STATUS_NONE,  '0},
        '{1'b0, "12\011:\012 34 \013:\01456\015, 789", 1'b0, STATUS_NONE, '0},
        '{1'b0, "1\010:2:3.000",        1'b0, STATUS_NONE,  '0},
        '{1'b0, "1:2:3.4567",           1'b0, STATUS_NONE,  '0},
        '{1'b0, "1:2:3:4,567",          1'b0, STATUS_NONE,  '0},
        '{1'b0, "1.2:3:4,567",          1'b0, STATUS_NONE,  '0},
        '{1'b0, "x12:34:5 y1:2:3,999",  1'b0, STATUS_NONE,  '0},
        '{1'b0, "1:2:3.456 9:9:9.999",  1'b0, STATUS_NONE,  '0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    // scan model state, one entry per attempt slot
    stage_t      slot_stage   [ATTEMPT_SLOTS];
    logic [63:0] slot_hours   [ATTEMPT_SLOTS];
    logic [63:0] slot_minutes [ATTEMPT_SLOTS];
    logic [63:0] slot_seconds [ATTEMPT_SLOTS];
    logic [9:0]  slot_millis  [ATTEMPT_SLOTS];
    int unsigned slot_frac    [ATTEMPT_SLOTS];
    bit          prev_digit;
    bit          have_match;
    logic [63:0] match_seconds;
    logic [9:0]  match_millis;

    scan_result_t pending_results [$];
    bit           pinned_on;
    scan_result_t pinned_result;
    int unsigned  mismatches  = 0;
    int unsigned  bytes_sent  = 0;
    int unsigned  cycle_count = 0;

    text_timecode_scanner u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ---------------------------------------------------------------- scan model

    function automatic bit is_digit_char(logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    // space plus tab, line feed, vertical tab, form feed and carriage return
    function automatic bit is_blank_char(logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit is_point_char(logic [7:0] c);
        return c == CHAR_PERIOD || c == CHAR_COMMA;
    endfunction

    // decimal accumulate that sticks at the top of the field
    function automatic logic [63:0] push_digit(logic [63:0] v, logic [3:0] d);
        if (v > (FIELD_TOP - 64'(d)) / 64'd10) return FIELD_TOP;
        return v * 64'd10 + 64'(d);
    endfunction

    function automatic logic [63:0] cap_field(logic [63:0] v);
        return (v > SECONDS_CAP) ? SECONDS_CAP + 64'd1 : v;
    endfunction

    function automatic void clear_scan_state();
        int k;
        for (k = 0; k < ATTEMPT_SLOTS; k++) begin
            slot_stage[k]   = ST_IDLE;
            slot_hours[k]   = '0;
            slot_minutes[k] = '0;
            slot_seconds[k] = '0;
            slot_millis[k]  = '0;
            slot_frac[k]    = 0;
        end
        prev_digit    = 1'b0;
        have_match    = 1'b0;
        match_seconds = '0;
        match_millis  = '0;
    endfunction

    // moves one slot on by one character, returns 1 once its third fraction digit is in
    function automatic bit step_slot(int k, logic [7:0] c);
        bit         dg;
        bit         sp;
        bit         pt;
        logic [3:0] d;
        stage_t     cur;
        stage_t     nxt;
        dg  = is_digit_char(c);
        sp  = is_blank_char(c);
        pt  = is_point_char(c);
        d   = dg ? 4'(c - CHAR_ZERO) : 4'd0;
        cur = slot_stage[k];
        nxt = ST_IDLE;
        case (cur)
            ST_HOURS, ST_MINUTES, ST_SECONDS: begin
                if (dg) begin
                    if (cur == ST_HOURS) slot_hours[k] = push_digit(slot_hours[k], d);
                    else if (cur == ST_MINUTES) slot_minutes[k] = push_digit(slot_minutes[k], d);
                    else slot_seconds[k] = push_digit(slot_seconds[k], d);
                    nxt = cur;
                end else if (sp) begin
                    if (cur == ST_HOURS) nxt = ST_SP_H;
                    else if (cur == ST_MINUTES) nxt = ST_SP_M;
                    else nxt = ST_SP_S;
                end else if (cur != ST_SECONDS && c == CHAR_COLON) begin
                    nxt = (cur == ST_HOURS) ? ST_SP_C1 : ST_SP_C2;
                end else if (cur == ST_SECONDS && pt) begin
                    nxt = ST_SP_DOT;
                end
            end
            ST_SP_H, ST_SP_M: begin
                if (sp) nxt = cur;
                else if (c == CHAR_COLON) nxt = (cur == ST_SP_H) ? ST_SP_C1 : ST_SP_C2;
            end
            ST_SP_S: begin
                if (sp) nxt = cur;
                else if (pt) nxt = ST_SP_DOT;
            end
            ST_SP_C1, ST_SP_C2: begin
                if (sp) begin
                    nxt = cur;
                end else if (dg) begin
                    if (cur == ST_SP_C1) begin
                        slot_minutes[k] = 64'(d);
                        nxt = ST_MINUTES;
                    end else begin
                        slot_seconds[k] = 64'(d);
                        nxt = ST_SECONDS;
                    end
                end
            end
            ST_SP_DOT: begin
                if (sp) begin
                    nxt = cur;
                end else if (dg) begin
                    slot_millis[k] = 10'(d);
                    slot_frac[k]   = 1;
                    nxt = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (dg) begin
                    slot_millis[k] = slot_millis[k] * 10'd10 + 10'(d);
                    slot_frac[k]++;
                    if (slot_frac[k] >= MILLI_DIGITS) begin
                        slot_stage[k] = ST_IDLE;
                        return 1'b1;
                    end
                    nxt = ST_FRAC;
                end
            end
            default: ;
        endcase
        slot_stage[k] = nxt;
        return 1'b0;
    endfunction

    // takes one accepted byte; on the last byte of a text it yields the text's result
    function automatic bit scan_byte(logic [7:0] c, bit last, output scan_result_t res);
        int          k;
        bit          dg;
        bit          placed;
        logic [63:0] total_ns;
        dg         = is_digit_char(c);
        res.status = STATUS_NONE;
        res.ns     = '0;
        if (!have_match) begin
            for (k = 0; k < ATTEMPT_SLOTS; k++) begin
                if (slot_stage[k] != ST_IDLE) begin
                    if (step_slot(k, c) && !have_match) begin
                        // first slot to finish holds the leftmost time code
                        have_match    = 1'b1;
                        match_seconds = cap_field(slot_hours[k]) * 64'd3600
                                      + cap_field(slot_minutes[k]) * 64'd60
                                      + cap_field(slot_seconds[k]);
                        match_millis  = slot_millis[k];
                    end
                end
            end
            // a digit run opens a new attempt in the first idle slot, if any
            if (!have_match && dg && !prev_digit) begin
                placed = 1'b0;
                for (k = 0; k < ATTEMPT_SLOTS; k++) begin
                    if (!placed && slot_stage[k] == ST_IDLE) begin
                        slot_stage[k]   = ST_HOURS;
                        slot_hours[k]   = 64'(c - CHAR_ZERO);
                        slot_minutes[k] = '0;
                        slot_seconds[k] = '0;
                        slot_millis[k]  = '0;
                        slot_frac[k]    = 0;
                        placed          = 1'b1;
                    end
                end
            end
        end
        prev_digit = dg;
        if (!last) return 1'b0;
        if (have_match) begin
            if (match_seconds > SECONDS_CAP) begin
                res.status = STATUS_RANGE;
            end else begin
                total_ns = match_seconds * 64'd1000000000 + 64'(match_millis) * 64'd1000000;
                if (total_ns > NS_CAP) begin
                    res.status = STATUS_RANGE;
                end else begin
                    res.status = STATUS_FOUND;
                    res.ns     = total_ns[NS_W-1:0];
                end
            end
        end
        clear_scan_state();
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what);
        mismatches++;
        $display("%0t  mismatch: %s", $time, what);
    endtask

    // one process both checks result words and feeds accepted bytes to the model,
    // so the outcome never hinges on process order within an edge
    always @(posedge aclk) begin
        scan_result_t want;
        scan_result_t predicted;
        if (!aresetn) begin
            clear_scan_state();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result word with none pending, tuser %0d tdata %0h",
                                              m_tuser, m_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("scan_status %0d, expected %0d",
                                                  m_tuser, want.status));
                    if (m_tdata[NS_W-1:0] !== want.ns)
                        report_mismatch($sformatf("time_ns %0d, expected %0d",
                                                  m_tdata[NS_W-1:0], want.ns));
                    if (m_tdata[OUT_DATA_W-1:NS_W] !== '0)
                        report_mismatch($sformatf("tdata pad bit %b, expected 0",
                                                  m_tdata[OUT_DATA_W-1:NS_W]));
                end
            end
            if (s_tvalid && s_tready) begin
                if (scan_byte(s_tdata, s_tlast, predicted))
                    pending_results.push_back(pinned_on ? pinned_result : predicted);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // idle length for either side: quiet stretches with none, else mostly none and otherwise mostly short gaps
    function automatic int unsigned idle_len();
        int unsigned pick;
        if ((cycle_count / 256) % 4 == 0) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void append_chars(ref byte_seq_t t, input string s);
        int i;
        for (i = 0; i < s.len(); i++) t.push_back(s[i]);
    endfunction

    function automatic void append_digits(ref byte_seq_t t, input int unsigned n);
        repeat (n) t.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] pick_point();
        return $urandom_range(0, 1) ? CHAR_PERIOD : CHAR_COMMA;
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(0, 255));
            1: return 8'("a") + 8'($urandom_range(0, 25));
            2: return CHAR_ZERO + 8'($urandom_range(0, 9));
            3: return $urandom_range(0, 1) ? CHAR_COLON : pick_point();
            default: return CHAR_TAB + 8'($urandom_range(0, CHAR_CR - CHAR_TAB));
        endcase
    endfunction

    // optional whitespace, usually none
    function automatic void append_blanks(ref byte_seq_t t);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2))
                t.push_back($urandom_range(0, 2) == 0 ? CHAR_SPACE
                            : CHAR_TAB + 8'($urandom_range(0, CHAR_CR - CHAR_TAB)));
        end
    endfunction

    // one component: mostly clock-sized, sometimes wide, now and then a run that saturates
    function automatic void append_field(ref byte_seq_t t);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) append_chars(t, $sformatf("%0d", $urandom_range(0, 59)));
        else if (pick < 75) append_chars(t, $sformatf("%02d", $urandom_range(0, 99)));
        else if (pick < 92) append_chars(t, $sformatf("%0d", $urandom_range(0, 999999)));
        else append_digits(t, $urandom_range(8, 14));
    endfunction

    function automatic void append_time_code(ref byte_seq_t t);
        append_field(t);
        append_blanks(t);
        t.push_back(CHAR_COLON);
        append_blanks(t);
        append_field(t);
        append_blanks(t);
        t.push_back(CHAR_COLON);
        append_blanks(t);
        append_field(t);
        append_blanks(t);
        t.push_back(pick_point());
        append_blanks(t);
        // short fractions leave the attempt unfinished
        append_digits(t, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                      : $urandom_range(3, 5));
    endfunction

    // time codes right at the seconds and nanosecond limits
    function automatic void append_limit_code(ref byte_seq_t t);
        int unsigned secs;
        int unsigned frac;
        secs = $urandom_range(0, 1) ? 16 : $urandom_range(15, 17);
        frac = $urandom_range(0, 1) ? $urandom_range(850, 859) : $urandom_range(0, 999);
        append_chars(t, $sformatf("2562047:47:%0d", secs));
        t.push_back(pick_point());
        append_chars(t, $sformatf("%03d", frac));
    endfunction

    function automatic void build_random_text(ref byte_seq_t t);
        int unsigned kind;
        t.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            // pure noise
            repeat ($urandom_range(1, 12)) t.push_back(noise_char());
            return;
        end
        repeat ($urandom_range(0, 3)) t.push_back(noise_char());
        if (kind < 22) append_limit_code(t);
        else append_time_code(t);
        if (kind >= 70 && kind < 80) begin
            // a second code that must be ignored
            t.push_back(CHAR_SPACE);
            append_time_code(t);
        end
        if (kind >= 82) t[$urandom_range(0, t.size() - 1)] = noise_char();
        repeat ($urandom_range(0, 3)) t.push_back(noise_char());
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_text(input byte_seq_t t);
        int i;
        for (i = 0; i < t.size(); i++) send_word(t[i], i == t.size() - 1);
        bytes_sent += t.size();
    endtask

    // sender holds off until every pending result word has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    // result side backpressure
    initial begin
        int unsigned hold;
        m_tready = 1'b0;
        hold     = 0;
        forever begin
            @(negedge aclk);
            if (hold == 0) hold = idle_len();
            if (hold == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                hold--;
            end
        end
    end

    initial begin
        byte_seq_t text;
        int        r;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        pinned_on     = 1'b0;
        pinned_result = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed texts: extremes, whitespace kinds, limits and the tricky separators
        for (r = 0; r < $size(directed_cases); r++) begin
            text.delete();
            if (directed_cases[r].lead_nul) text.push_back(8'h00);
            append_chars(text, directed_cases[r].text);
            pinned_on            = directed_cases[r].pinned;
            pinned_result.status = directed_cases[r].status;
            pinned_result.ns     = directed_cases[r].ns;
            send_text(text);
        end
        pinned_on = 1'b0;
        wait_for_results();

        // random texts, mostly well-formed codes in noise
        while (bytes_sent < TEXT_BYTES) begin
            build_random_text(text);
            send_text(text);
            if ($urandom_range(0, 11) == 0) wait_for_results();
        end
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb_text_timecode_scanner OK");
        end else begin
            $display("tb_text_timecode_scanner NOT OK");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("tb_text_timecode_scanner NOT OK");
        $finish;
    end

endmodule
